[hdl/bfsp_pkg.sv]
package bfsp_pkg;

    localparam int MAX_VERTICES = 32;
    localparam int MAX_EDGES    = 32;
    localparam int VTX_BITS     = $clog2(MAX_VERTICES);
    localparam int EDGE_BITS    = $clog2(MAX_EDGES);
    localparam int CNT_BITS     = 6;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 21;
    localparam int CFG_IDX_BITS = 1;

    typedef logic [VTX_BITS-1:0]         t_vtx;
    typedef logic [EDGE_BITS-1:0]        t_edge_addr;
    typedef logic [CNT_BITS-1:0]         t_cnt;
    typedef logic signed [WEIGHT_BITS-1:0] t_weight;
    typedef logic signed [DIST_BITS-1:0] t_dist;
    typedef logic [CFG_IDX_BITS-1:0]     t_cfg_idx;

    localparam t_cfg_idx CFG_VERTEX_COUNT = 1'b0;
    localparam t_cfg_idx CFG_EDGE_COUNT   = 1'b1;

    localparam t_cnt VERTEX_COUNT_RESET = t_cnt'(32);
    localparam t_cnt EDGE_COUNT_RESET   = t_cnt'(0);

    localparam t_dist DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
    localparam t_dist DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

    typedef struct packed {
        logic       load;
        logic       init;
        logic       edge_rd;
        t_edge_addr edge_addr;
        logic       dist_rd;
        logic       relax;
        logic       out_rd;
        t_vtx       out_vtx;
        logic       out_last;
        logic       out_cyc;
        t_cnt       nv;
    } t_cmd;

    typedef struct packed {
        logic hit;
    } t_status;

endpackage

[hdl/bfsp_datapath.sv]
module bfsp_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bfsp_pkg::t_cmd        i_cmd,
    input  bfsp_pkg::t_edge_addr  i_edge_index,
    input  bfsp_pkg::t_vtx        i_edge_from,
    input  bfsp_pkg::t_vtx        i_edge_to,
    input  bfsp_pkg::t_weight     i_edge_weight,
    input  bfsp_pkg::t_vtx        i_source_vertex,
    output bfsp_pkg::t_status     o_status,
    output logic                  o_valid,
    output bfsp_pkg::t_vtx        o_vertex,
    output bfsp_pkg::t_dist       o_distance,
    output logic                  o_unreachable,
    output logic                  o_negative_cycle,
    output logic                  o_last
);

    // edge store and distance store
    bfsp_pkg::t_vtx    r_from_mem   [bfsp_pkg::MAX_EDGES];
    bfsp_pkg::t_vtx    r_to_mem     [bfsp_pkg::MAX_EDGES];
    bfsp_pkg::t_weight r_weight_mem [bfsp_pkg::MAX_EDGES];
    bfsp_pkg::t_dist   r_dist_mem   [bfsp_pkg::MAX_VERTICES];
    logic [bfsp_pkg::MAX_VERTICES-1:0] r_reached;

    bfsp_pkg::t_vtx    r_e_from;
    bfsp_pkg::t_vtx    r_e_to;
    bfsp_pkg::t_weight r_e_w;
    bfsp_pkg::t_dist   r_dx;
    bfsp_pkg::t_dist   r_dy;
    logic              r_rx;
    logic              r_ry;

    logic              r_valid;
    bfsp_pkg::t_vtx    r_vertex;
    bfsp_pkg::t_dist   r_distance;
    logic              r_unreachable;
    logic              r_negative_cycle;
    logic              r_last;

    logic signed [bfsp_pkg::DIST_BITS:0] sum;
    bfsp_pkg::t_dist   cand;
    logic              in_range;
    logic              hit;
    logic [bfsp_pkg::MAX_VERTICES-1:0] src_mask;

    always_comb begin
        sum = (bfsp_pkg::DIST_BITS+1)'(r_dx)
            + (bfsp_pkg::DIST_BITS+1)'(r_e_w);
        if (sum > (bfsp_pkg::DIST_BITS+1)'(bfsp_pkg::DIST_MAX)) begin
            cand = bfsp_pkg::DIST_MAX;
        end else if (sum < (bfsp_pkg::DIST_BITS+1)'(bfsp_pkg::DIST_MIN)) begin
            cand = bfsp_pkg::DIST_MIN;
        end else begin
            cand = sum[bfsp_pkg::DIST_BITS-1:0];
        end
        in_range = ({1'b0, r_e_from} < i_cmd.nv) && ({1'b0, r_e_to} < i_cmd.nv);
        hit = in_range && r_rx && (!r_ry || (cand < r_dy));
        if ({1'b0, i_source_vertex} < i_cmd.nv) begin
            src_mask = {{(bfsp_pkg::MAX_VERTICES-1){1'b0}}, 1'b1} << i_source_vertex;
        end else begin
            src_mask = '0;
        end
    end

    assign o_status.hit = hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_from_mem[i_edge_index]   <= i_edge_from;
            r_to_mem[i_edge_index]     <= i_edge_to;
            r_weight_mem[i_edge_index] <= i_edge_weight;
        end
        if (i_cmd.edge_rd) begin
            r_e_from <= r_from_mem[i_cmd.edge_addr];
            r_e_to   <= r_to_mem[i_cmd.edge_addr];
            r_e_w    <= r_weight_mem[i_cmd.edge_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.relax && hit) begin
            r_dist_mem[r_e_to] <= cand;
        end
        if (i_cmd.init) begin
            r_dist_mem[i_source_vertex] <= '0;
        end
        if (i_cmd.dist_rd) begin
            r_dx <= r_dist_mem[r_e_from];
            r_dy <= r_dist_mem[r_e_to];
            r_rx <= r_reached[r_e_from];
            r_ry <= r_reached[r_e_to];
        end
        if (i_cmd.out_rd) begin
            r_vertex      <= i_cmd.out_vtx;
            r_distance    <= r_reached[i_cmd.out_vtx] ? r_dist_mem[i_cmd.out_vtx] : '0;
            r_unreachable <= !r_reached[i_cmd.out_vtx];
        end else if (i_cmd.out_cyc) begin
            r_vertex      <= '0;
            r_distance    <= '0;
            r_unreachable <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached        <= '0;
            r_valid          <= 1'b0;
            r_negative_cycle <= 1'b0;
            r_last           <= 1'b0;
        end else begin
            if (i_cmd.init) begin
                r_reached <= src_mask;
            end else if (i_cmd.relax && hit) begin
                r_reached[r_e_to] <= 1'b1;
            end
            r_valid          <= i_cmd.out_rd || i_cmd.out_cyc;
            r_negative_cycle <= i_cmd.out_cyc;
            r_last           <= i_cmd.out_cyc || (i_cmd.out_rd && i_cmd.out_last);
        end
    end

    assign o_valid          = r_valid;
    assign o_vertex         = r_vertex;
    assign o_distance       = r_distance;
    assign o_unreachable    = r_unreachable;
    assign o_negative_cycle = r_negative_cycle;
    assign o_last           = r_last;

endmodule

[hdl/bfsp_controller.sv]
module bfsp_controller (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_mode,
    input  logic                 i_cfg_we,
    input  bfsp_pkg::t_cfg_idx   i_cfg_index,
    input  bfsp_pkg::t_cnt       i_cfg_data,
    input  bfsp_pkg::t_status    i_status,
    output bfsp_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_RELAX,
        S_OUT,
        S_CYC
    } t_state;

    t_state               r_state;
    bfsp_pkg::t_cnt       r_vertex_count;
    bfsp_pkg::t_cnt       r_edge_count;
    bfsp_pkg::t_edge_addr r_edge;
    bfsp_pkg::t_vtx       r_pass;
    bfsp_pkg::t_vtx       r_vtx;
    logic                 r_check;

    bfsp_pkg::t_cnt       nv;
    bfsp_pkg::t_cnt       ne;
    logic                 accept;
    logic                 run;
    logic                 last_edge;
    logic                 last_vtx;
    logic                 next_is_check;

    always_comb begin
        if (r_vertex_count == '0) begin
            nv = bfsp_pkg::t_cnt'(1);
        end else if (r_vertex_count > bfsp_pkg::t_cnt'(bfsp_pkg::MAX_VERTICES)) begin
            nv = bfsp_pkg::t_cnt'(bfsp_pkg::MAX_VERTICES);
        end else begin
            nv = r_vertex_count;
        end
        if (r_edge_count > bfsp_pkg::t_cnt'(bfsp_pkg::MAX_EDGES)) begin
            ne = bfsp_pkg::t_cnt'(bfsp_pkg::MAX_EDGES);
        end else begin
            ne = r_edge_count;
        end
        accept        = i_start && (r_state == S_IDLE);
        run           = accept && i_mode;
        last_edge     = ({1'b0, r_edge} + bfsp_pkg::t_cnt'(1)) == ne;
        last_vtx      = ({1'b0, r_vtx} + bfsp_pkg::t_cnt'(1)) == nv;
        next_is_check = ({1'b0, r_pass} + bfsp_pkg::t_cnt'(2)) >= nv;
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.nv        = nv;
        o_cmd.load      = accept && !i_mode;
        o_cmd.init      = run;
        o_cmd.out_vtx   = r_vtx;
        o_cmd.out_last  = last_vtx;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.edge_rd   = run;
                o_cmd.edge_addr = '0;
            end
            S_READ: begin
                o_cmd.dist_rd = 1'b1;
            end
            S_RELAX: begin
                o_cmd.relax     = !r_check;
                o_cmd.edge_rd   = 1'b1;
                o_cmd.edge_addr = last_edge ? '0 : r_edge + bfsp_pkg::t_edge_addr'(1);
            end
            S_OUT: begin
                o_cmd.out_rd = 1'b1;
            end
            S_CYC: begin
                o_cmd.out_cyc = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= bfsp_pkg::VERTEX_COUNT_RESET;
            r_edge_count   <= bfsp_pkg::EDGE_COUNT_RESET;
            r_edge         <= '0;
            r_pass         <= '0;
            r_vtx          <= '0;
            r_check        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    bfsp_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                    bfsp_pkg::CFG_EDGE_COUNT:   r_edge_count   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (run) begin
                        r_edge  <= '0;
                        r_pass  <= '0;
                        r_vtx   <= '0;
                        r_check <= (nv == bfsp_pkg::t_cnt'(1));
                        r_state <= (ne == '0) ? S_OUT : S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_RELAX;
                end
                S_RELAX: begin
                    if (r_check && i_status.hit) begin
                        r_state <= S_CYC;
                    end else if (last_edge) begin
                        r_edge <= '0;
                        if (r_check) begin
                            r_state <= S_OUT;
                        end else begin
                            r_pass  <= r_pass + bfsp_pkg::t_vtx'(1);
                            r_check <= next_is_check;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_edge  <= r_edge + bfsp_pkg::t_edge_addr'(1);
                        r_state <= S_READ;
                    end
                end
                S_OUT: begin
                    if (last_vtx) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_vtx <= r_vtx + bfsp_pkg::t_vtx'(1);
                    end
                end
                S_CYC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[hdl/bellman_ford_shortest_paths_core.sv]
// Single-source shortest paths over up to 32 vertices and 32 stored edges. A load request
// (mode 0) writes one edge slot and gives no result; busy stays low. A run request
// (mode 1) relaxes every edge vertex_count-1 times and checks once for a reachable
// negative cycle; each edge passes through a READ state (distance store read) and a
// RELAX state (distance store update, overlapped with the following edge store read),
// so each edge's distance read comes after the previous update. It then gives either
// one negative-cycle result or one result per vertex on consecutive cycles, each shown
// for exactly one cycle with o_valid; results cannot be held off, so the receiver must
// take every strobe. busy falls once the last result is registered.
module bellman_ford_shortest_paths_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_mode,
    input  logic [4:0]                 i_edge_index,
    input  logic [4:0]                 i_edge_from,
    input  logic [4:0]                 i_edge_to,
    input  logic signed [15:0]         i_edge_weight,
    input  logic [4:0]                 i_source_vertex,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [5:0]                 i_cfg_data,
    output logic                       o_valid,
    output logic [4:0]                 o_vertex,
    output logic signed [20:0]         o_distance,
    output logic                       o_unreachable,
    output logic                       o_negative_cycle,
    output logic                       o_last
);

    bfsp_pkg::t_cmd    cmd;
    bfsp_pkg::t_status status;

    bfsp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_mode      (i_mode),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    bfsp_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_edge_index     (i_edge_index),
        .i_edge_from      (i_edge_from),
        .i_edge_to        (i_edge_to),
        .i_edge_weight    (i_edge_weight),
        .i_source_vertex  (i_source_vertex),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_vertex         (o_vertex),
        .o_distance       (o_distance),
        .o_unreachable    (o_unreachable),
        .o_negative_cycle (o_negative_cycle),
        .o_last           (o_last)
    );

endmodule

[hdl/bfsp_checker.sv]
module bfsp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              i_mode,
    input logic              o_busy,
    input logic              o_valid,
    input logic [4:0]        o_vertex,
    input logic signed [20:0] o_distance,
    input logic              o_unreachable,
    input logic              o_negative_cycle,
    input logic              o_last
);

    a_cycle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_negative_cycle |->
            o_last && (o_vertex == 5'd0) && (o_distance == 21'sd0) && !o_unreachable)
        else $error("negative cycle result malformed");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unreachable |-> (o_distance == 21'sd0))
        else $error("unreachable vertex with nonzero distance");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid && (o_vertex == $past(o_vertex) + 5'd1))
        else $error("vertex results not consecutive");

    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && !i_mode |=> !o_busy && !o_valid)
        else $error("load request started work");

endmodule

bind bellman_ford_shortest_paths_core bfsp_checker u_bfsp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_start          (i_start),
    .i_mode           (i_mode),
    .o_busy           (o_busy),
    .o_valid          (o_valid),
    .o_vertex         (o_vertex),
    .o_distance       (o_distance),
    .o_unreachable    (o_unreachable),
    .o_negative_cycle (o_negative_cycle),
    .o_last           (o_last)
);
